[src/difficulty_target_retarget_macros.svh]
// Assertion macros shared by the retarget RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef DIFFICULTY_TARGET_RETARGET_MACROS_SVH
`define DIFFICULTY_TARGET_RETARGET_MACROS_SVH
`ifndef SYNTHESIS
`define DTR_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("dtr assertion failed");
`define DTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtr assertion failed");
`else
`define DTR_ASSERT(lbl, expr)
`define DTR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/dtr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the compact-target decoder for the retarget block.
// No dependencies.
package dtr_pkg;

  localparam int TARGET_BITS = 256;
  localparam int STEP_BITS   = 8;                       // quotient bits per cell
  localparam int NCELL       = TARGET_BITS / STEP_BITS;
  localparam int LIMB_W      = 32;
  localparam int NLIMB       = TARGET_BITS / LIMB_W;
  localparam int SP_W        = 17;
  localparam int TS_W        = 24;
  localparam int SP10_W      = 21;
  localparam int DV_W        = 25;                      // divisor and multiplier width
  localparam int PP_W        = LIMB_W + DV_W;
  localparam int CNT_W       = 5;
  localparam int IDX_W       = 3;
  localparam int SIZE_W      = 6;
  localparam int CAP_FACTOR  = 10;

  localparam logic [SP_W-1:0] SPACING_RST  = 17'd60;
  localparam logic [TS_W-1:0] TIMESPAN_RST = 24'd960;
  localparam logic [31:0]     LIMIT_RST    = 32'h1d00ffff;

  typedef enum logic [IDX_W-1:0] {
    REG_SPACING     = 3'd0,
    REG_TIMESPAN    = 3'd1,
    REG_WORK_LIMIT  = 3'd2,
    REG_STAKE_LIMIT = 3'd3,
    REG_WORK_FIXED  = 3'd4,
    REG_STAKE_FIXED = 3'd5
  } reg_idx_t;

  typedef logic [TARGET_BITS-1:0] wide_t;

  typedef struct packed {
    logic        fixed;
    logic        stake;
    logic [31:0] bits;
  } side_t;

  typedef struct packed {
    wide_t           num;
    logic [DV_W-1:0] rem;
    side_t           side;
  } cell_data_t;

  typedef struct packed {
    logic              ready;
    logic [SP_W-1:0]   sp;
    logic [SP10_W-1:0] sp10;
    logic [TS_W-1:0]   base;
    logic [DV_W-1:0]   dv;
    logic              work_fixed;
    logic              stake_fixed;
    wide_t             lim_work;
    wide_t             lim_stake;
  } cfg_t;

  // Compact bits to a 256-bit value; sign bit ignored, overflow lost.
  function automatic wide_t dtr_decode(input logic [31:0] bits);
    logic [7:0]   size;
    logic [303:0] t;
    size = bits[31:24];
    t = 304'(bits[22:0]) << {size[5:0], 3'b000};
    if (size > 8'd34) begin
      return '0;
    end
    return t[279:24];
  endfunction

endpackage

[src/dtr_cfg.sv]
`timescale 1ns / 1ps
// Configuration registers, spacing-derived constants and decoded limits.
// Depends on dtr_pkg.
module dtr_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dtr_pkg::IDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  output dtr_pkg::cfg_t             cfg_o
);
  import dtr_pkg::*;

  logic [SP_W-1:0]  spacing_r;
  logic [TS_W-1:0]  timespan_r;
  logic [31:0]      work_lim_r, stake_lim_r;
  logic             work_fixed_r, stake_fixed_r;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SP_W-1:0]  rem_r, rem_nxt;
  logic [TS_W-1:0]  base_r;
  logic [DV_W-1:0]  dv_r;
  wide_t            lim_work_r, lim_stake_r;
  logic [SP_W-1:0]  sp_eff;
  logic [SP_W:0]    r_step;
  logic [SP_W-1:0]  rem_step;
  logic [TS_W-1:0]  prod;
  logic             wr;
  logic             done;

  assign wr        = cfg_valid && cfg_ready;
  assign cfg_ready = !busy_r;
  assign sp_eff    = (spacing_r == '0) ? SP_W'(1) : spacing_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r     <= SPACING_RST;
      timespan_r    <= TIMESPAN_RST;
      work_lim_r    <= LIMIT_RST;
      stake_lim_r   <= LIMIT_RST;
      work_fixed_r  <= 1'b0;
      stake_fixed_r <= 1'b0;
    end else if (wr) begin
      case (reg_idx_t'(cfg_index))
        REG_SPACING:     spacing_r     <= cfg_data[SP_W-1:0];
        REG_TIMESPAN:    timespan_r    <= cfg_data[TS_W-1:0];
        REG_WORK_LIMIT:  work_lim_r    <= cfg_data;
        REG_STAKE_LIMIT: stake_lim_r   <= cfg_data;
        REG_WORK_FIXED:  work_fixed_r  <= cfg_data[0];
        REG_STAKE_FIXED: stake_fixed_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Bit-serial remainder of timespan by spacing, one bit a cycle
  always_comb begin
    r_step   = {rem_r, timespan_r[CNT_W'(TS_W-1) - cnt_r]};
    rem_step = (r_step >= {1'b0, sp_eff}) ? SP_W'(r_step - {1'b0, sp_eff}) : r_step[SP_W-1:0];
    done     = busy_r && (cnt_r == CNT_W'(TS_W-1));
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    if (wr) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
    // interval * spacing, interval raised to one
    prod = (timespan_r < TS_W'(sp_eff)) ? TS_W'(sp_eff) : timespan_r - TS_W'(rem_step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // Derived constants and decoded limits
  always_ff @(posedge clk) begin
    if (done) begin
      base_r <= prod - TS_W'(sp_eff);
      dv_r   <= DV_W'(prod) + DV_W'(sp_eff);
    end
    lim_work_r  <= dtr_decode(work_lim_r);
    lim_stake_r <= dtr_decode(stake_lim_r);
  end

  always_comb begin
    cfg_o.ready       = !busy_r;
    cfg_o.sp          = sp_eff;
    cfg_o.sp10        = SP10_W'(SP10_W'(sp_eff) * SP10_W'(CAP_FACTOR));
    cfg_o.base        = base_r;
    cfg_o.dv          = dv_r;
    cfg_o.work_fixed  = work_fixed_r;
    cfg_o.stake_fixed = stake_fixed_r;
    cfg_o.lim_work    = lim_work_r;
    cfg_o.lim_stake   = lim_stake_r;
  end

endmodule

[src/dtr_cell.sv]
`timescale 1ns / 1ps
// One divider cell: eight restoring quotient steps, then a pipeline register.
// Depends on dtr_pkg.
module dtr_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [dtr_pkg::DV_W-1:0] dv,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  dtr_pkg::cell_data_t      data_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output dtr_pkg::cell_data_t      data_o
);
  import dtr_pkg::*;

  logic       v_r;
  cell_data_t d_r, d_nxt;
  logic [DV_W:0] r;

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;
  assign data_o  = d_r;

  // Shift dividend bits into the remainder, quotient bits in at the bottom
  always_comb begin
    d_nxt = data_i;
    r     = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      r = {d_nxt.rem, d_nxt.num[TARGET_BITS-1]};
      d_nxt.num = {d_nxt.num[TARGET_BITS-2:0], 1'b0};
      if (r >= {1'b0, dv}) begin
        r = r - {1'b0, dv};
        d_nxt.num[0] = 1'b1;
      end
      d_nxt.rem = r[DV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      d_r <= d_nxt;
    end
  end

endmodule

[src/difficulty_target_retarget.sv]
`timescale 1ns / 1ps
// Top level: spacing bound, target decode, 256x25 multiply, divider cell row, clamp, encode.
// Depends on dtr_pkg, dtr_cfg, dtr_cell and the macros header.
// Pipeline: 3 front stages, 32 divider cells of 8 quotient bits, 3 encode stages.
// One item per cycle unless out_ready or a config rebuild stalls; divider cells set the depth.
// Reset is synchronous, active low; after reset and after every config write the
// block is not ready while the spacing remainder is rebuilt bit-serially.
`include "difficulty_target_retarget_macros.svh"
module difficulty_target_retarget (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               in_last_bits,
  input  logic [31:0]               in_last_time,
  input  logic [31:0]               in_first_time,
  input  logic                      in_is_stake,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [31:0]               out_next_bits,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dtr_pkg::IDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);
  import dtr_pkg::*;

  cfg_t cfg;

  dtr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Stage handshakes: a stage loads when empty or when it drains
  logic s1_v_r, s2_v_r, s3_v_r, e1_v_r, e2_v_r, out_v_r;
  logic s1_acc, s2_acc, s3_acc, e1_acc, e2_acc, out_acc;
  logic cell_v   [NCELL+1];
  logic cell_rdy [NCELL+1];
  cell_data_t cell_d [NCELL+1];

  assign out_acc = !out_v_r || out_ready;
  assign e2_acc  = !e2_v_r || out_acc;
  assign e1_acc  = !e1_v_r || e2_acc;
  assign cell_rdy[NCELL] = e1_acc;
  assign s3_acc  = !s3_v_r || cell_rdy[0];
  assign s2_acc  = !s2_v_r || s3_acc;
  assign s1_acc  = !s1_v_r || s2_acc;
  assign in_ready = s1_acc && cfg.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      e1_v_r  <= 1'b0;
      e2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_acc)  s1_v_r  <= in_valid && cfg.ready;
      if (s2_acc)  s2_v_r  <= s1_v_r;
      if (s3_acc)  s3_v_r  <= s2_v_r;
      if (e1_acc)  e1_v_r  <= cell_v[NCELL];
      if (e2_acc)  e2_v_r  <= e1_v_r;
      if (out_acc) out_v_r <= e2_v_r;
    end
  end

  // Stage 1: bound the spacing, build the multiplier, decode the target
  logic signed [32:0] diff;
  logic [SP10_W-1:0]  actual;
  side_t              s1_side_r;
  wide_t              s1_tgt_r;
  logic [DV_W-1:0]    s1_mult_r;

  always_comb begin
    diff = $signed({1'b0, in_last_time}) - $signed({1'b0, in_first_time});
    if (diff < 0) begin
      actual = SP10_W'(cfg.sp);
    end else if (diff > $signed({12'b0, cfg.sp10})) begin
      actual = cfg.sp10;
    end else begin
      actual = diff[SP10_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_acc && in_valid && in_ready) begin
      s1_side_r.fixed <= in_is_stake ? cfg.stake_fixed : cfg.work_fixed;
      s1_side_r.stake <= in_is_stake;
      s1_side_r.bits  <= in_last_bits;
      s1_tgt_r        <= dtr_decode(in_last_bits);
      s1_mult_r       <= DV_W'(cfg.base) + DV_W'({actual, 1'b0});
    end
  end

  // Stage 2: one 32x25 partial product per limb
  logic [PP_W-1:0] s2_pp_r [NLIMB];
  side_t           s2_side_r;

  always_ff @(posedge clk) begin
    if (s2_acc && s1_v_r) begin
      s2_side_r <= s1_side_r;
      for (int i = 0; i < NLIMB; i++) begin
        s2_pp_r[i] <= PP_W'(s1_tgt_r[i*LIMB_W +: LIMB_W]) * PP_W'(s1_mult_r);
      end
    end
  end

  // Stage 3: even and odd limbs do not overlap; one wide add, wrapping
  logic [TARGET_BITS-1:0] even_w;
  logic [TARGET_BITS+LIMB_W-1:0] odd_w;
  wide_t s3_prod_r;
  side_t s3_side_r;

  always_comb begin
    even_w = {7'b0, s2_pp_r[6], 7'b0, s2_pp_r[4], 7'b0, s2_pp_r[2], 7'b0, s2_pp_r[0]};
    odd_w  = {7'b0, s2_pp_r[7], 7'b0, s2_pp_r[5], 7'b0, s2_pp_r[3], 7'b0, s2_pp_r[1],
              32'b0};
  end

  always_ff @(posedge clk) begin
    if (s3_acc && s2_v_r) begin
      s3_prod_r <= even_w + odd_w[TARGET_BITS-1:0];
      s3_side_r <= s2_side_r;
    end
  end

  // Divider cell row
  assign cell_v[0]      = s3_v_r;
  assign cell_d[0].num  = s3_prod_r;
  assign cell_d[0].rem  = '0;
  assign cell_d[0].side = s3_side_r;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    dtr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .dv      (cfg.dv),
      .valid_i (cell_v[c]),
      .ready_o (cell_rdy[c]),
      .data_i  (cell_d[c]),
      .valid_o (cell_v[c+1]),
      .ready_i (cell_rdy[c+1]),
      .data_o  (cell_d[c+1])
    );
  end

  // E1: clamp to the kind's limit; a zero quotient also takes the limit
  wide_t e1_val_r, lim_sel, quo;
  side_t e1_side_r;

  assign quo     = cell_d[NCELL].num;
  assign lim_sel = cell_d[NCELL].side.stake ? cfg.lim_stake : cfg.lim_work;

  always_ff @(posedge clk) begin
    if (e1_acc && cell_v[NCELL]) begin
      e1_val_r  <= ((quo == '0) || (quo > lim_sel)) ? lim_sel : quo;
      e1_side_r <= cell_d[NCELL].side;
    end
  end

  // E2: byte size of the value
  logic [SIZE_W-1:0] size_c, e2_size_r;
  wide_t e2_val_r;
  side_t e2_side_r;

  always_comb begin
    size_c = '0;
    for (int b = 0; b < TARGET_BITS / 8; b++) begin
      if (e1_val_r[b*8 +: 8] != 8'b0) begin
        size_c = SIZE_W'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e2_acc && e1_v_r) begin
      e2_size_r <= size_c;
      e2_val_r  <= e1_val_r;
      e2_side_r <= e1_side_r;
    end
  end

  // Output: fixed sides pass their input bits; else pick the top three bytes, keep the sign bit clear
  logic [TARGET_BITS+23:0] ext;
  logic [23:0]             mant;
  logic [7:0]              size_fin;
  logic [31:0]             out_bits_r;
  logic                    out_fixed_r;

  always_comb begin
    ext      = {e2_val_r, 24'b0} >> {e2_size_r, 3'b000};
    mant     = ext[23:0];
    size_fin = 8'(e2_size_r);
    if (mant[23]) begin
      mant     = {8'b0, mant[23:8]};
      size_fin = size_fin + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc && e2_v_r) begin
      out_bits_r  <= e2_side_r.fixed ? e2_side_r.bits : {size_fin, mant};
      out_fixed_r <= e2_side_r.fixed;
    end
  end

  assign out_valid     = out_v_r;
  assign out_next_bits = out_bits_r;

  // No beat taken on the input while constants are rebuilt
  `DTR_ASSERT(a_no_in_while_busy, !(in_valid && in_ready && !cfg_ready))
  // A config beat blocks input on the following cycle
  `DTR_ASSERT_NEXT(a_cfg_blocks_in, cfg_valid && cfg_ready, !in_ready && !cfg_ready)
  // Encoded results never carry the sign bit
  `DTR_ASSERT(a_no_sign_bit, !(out_v_r && !out_fixed_r && out_bits_r[23]))

endmodule

[bench/difficulty_target_retarget_tb.sv]
`timescale 1ns / 1ps
// Testbench for difficulty_target_retarget: random and directed retarget requests,
// checked against an in-bench 256-bit predictor. Depends on dtr_pkg and the RTL.
module difficulty_target_retarget_tb;
  import dtr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 50;
  localparam int LONG_HOLD      = 500;
  localparam logic [IDX_W-1:0] IDX_UNUSED_A = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_UNUSED_B = IDX_W'(7);

  // Predicts next compact bits and holds the targets still owed by the block.
  class retarget_scoreboard;
    logic [16:0] spacing;
    logic [23:0] timespan;
    logic [31:0] work_limit;
    logic [31:0] stake_limit;
    logic        work_fixed;
    logic        stake_fixed;
    logic [31:0] owed_bits[$];
    int          errors;

    function new();
      spacing     = SPACING_RST;
      timespan    = TIMESPAN_RST;
      work_limit  = LIMIT_RST;
      stake_limit = LIMIT_RST;
      work_fixed  = 1'b0;
      stake_fixed = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_SPACING:     spacing     = data[16:0];
        REG_TIMESPAN:    timespan    = data[23:0];
        REG_WORK_LIMIT:  work_limit  = data;
        REG_STAKE_LIMIT: stake_limit = data;
        REG_WORK_FIXED:  work_fixed  = data[0];
        REG_STAKE_FIXED: stake_fixed = data[0];
        default: ;
      endcase
    endfunction

    function logic [255:0] expand(logic [31:0] bits);
      int unsigned sz;
      logic [255:0] v;
      sz = bits[31:24];
      v = 256'(bits[22:0]);
      if (sz <= 3) return v >> (8 * (3 - sz));
      if (sz - 3 >= 32) return '0;
      return v << (8 * (sz - 3));
    endfunction

    function logic [31:0] compress(logic [255:0] v);
      int unsigned len, sz;
      logic [255:0] t;
      logic [31:0] mant;
      len = 0;
      for (int i = 255; i >= 0; i--) begin
        if (v[i]) begin
          len = i + 1;
          break;
        end
      end
      sz = (len + 7) / 8;
      if (sz <= 3) begin
        mant = v[31:0] << (8 * (3 - sz));
      end else begin
        t = v >> (8 * (sz - 3));
        mant = t[31:0];
      end
      if (mant[23]) begin
        mant = mant >> 8;
        sz++;
      end
      return {sz[7:0], mant[23:0]};
    endfunction

    function logic [31:0] next_target(logic [31:0] bits, logic [31:0] t_last,
                                      logic [31:0] t_first, logic stake);
      longint sp, actual, interval;
      logic [63:0] mult, dv;
      logic [255:0] tgt, lim;
      if ((!stake && work_fixed) || (stake && stake_fixed)) return bits;
      sp = (spacing != 0) ? longint'(spacing) : 1;
      actual = longint'({1'b0, t_last}) - longint'({1'b0, t_first});
      if (actual < 0) actual = sp;
      if (actual > sp * 10) actual = sp * 10;
      interval = longint'(timespan) / sp;
      if (interval < 1) interval = 1;
      mult = (interval - 1) * sp + 2 * actual;
      dv = (interval + 1) * sp;
      lim = expand(stake ? stake_limit : work_limit);
      tgt = expand(bits) * 256'(mult);
      tgt = tgt / 256'(dv);
      if (tgt == '0 || tgt > lim) tgt = lim;
      return compress(tgt);
    endfunction

    function void note_request(logic [31:0] bits, logic [31:0] t_last,
                               logic [31:0] t_first, logic stake);
      owed_bits.push_back(next_target(bits, t_last, t_first, stake));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] exp_bits;
      if (owed_bits.size() == 0) begin
        $error("unexpected result beat: next_bits=%h", got);
        errors++;
        return;
      end
      exp_bits = owed_bits.pop_front();
      if (got !== exp_bits) begin
        $error("next_bits mismatch: expected %h actual %h", exp_bits, got);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [31:0]      in_last_bits;
  logic [31:0]      in_last_time;
  logic [31:0]      in_first_time;
  logic             in_is_stake;
  logic             out_valid;
  logic             out_ready;
  logic [31:0]      out_next_bits;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [31:0]      cfg_data;

  retarget_scoreboard sb;
  int                 results_seen;
  int                 idle_cycles = 0;

  difficulty_target_retarget i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_last_bits(in_last_bits), .in_last_time(in_last_time),
    .in_first_time(in_first_time), .in_is_stake(in_is_stake),
    .out_valid(out_valid), .out_ready(out_ready), .out_next_bits(out_next_bits),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stall per beat, one long hold-off
  initial begin
    int gap;
    results_seen = 0;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = (results_seen == 150) ? LONG_HOLD : $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0 && results_seen != 150) gap = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_next_bits);
      results_seen++;
    end
  end

  task automatic send_request(logic [31:0] bits, logic [31:0] t_last,
                              logic [31:0] t_first, logic stake, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_last_bits  <= bits;
    in_last_time  <= t_last;
    in_first_time <= t_first;
    in_is_stake   <= stake;
    do @(posedge clk); while (!in_ready);
    sb.note_request(bits, t_last, t_first, stake);
  endtask

  // Leaves cfg_valid high; cfg_close lowers it after a batch
  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_close();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all owed results, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.owed_bits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_burst(int count, bit stalls);
    logic [31:0] bits, t0, t1;
    int gap;
    for (int n = 0; n < count; n++) begin
      bits = $urandom;
      case ($urandom_range(0, 3))
        0: bits[31:24] = 8'($urandom_range(0, 3));
        1: bits[31:24] = 8'($urandom_range(4, 34));
        2: bits[31:24] = 8'($urandom_range(24, 31));
        default: ;
      endcase
      t0 = $urandom;
      case ($urandom_range(0, 4))
        0: t1 = $urandom;
        1: t1 = t0 - $urandom_range(0, 2000);
        2: t1 = t0 + $urandom_range(0, 300);
        3: t1 = t0 + $urandom_range(0, 2000000);
        default: t1 = t0 + $urandom_range(0, 1000);
      endcase
      gap = (stalls && $urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : 0;
      send_request(bits, t1, t0, 1'($urandom_range(0, 1)), gap);
    end
  endtask

  task automatic set_all(logic [31:0] sp, logic [31:0] ts, logic [31:0] wl,
                         logic [31:0] sl, logic wf, logic sf);
    cfg_write(REG_SPACING, sp);
    cfg_write(REG_TIMESPAN, ts);
    cfg_write(REG_WORK_LIMIT, wl);
    cfg_write(REG_STAKE_LIMIT, sl);
    cfg_write(REG_WORK_FIXED, {31'd0, wf});
    cfg_write(REG_STAKE_FIXED, {31'd0, sf});
    cfg_close();
  endtask

  initial begin
    sb = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_last_bits  = '0;
    in_last_time  = '0;
    in_first_time = '0;
    in_is_stake   = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: compact extremes, sign bit, overflowing exponents, spacing bounds
    send_request(32'h00000000, 32'd1000, 32'd940, 1'b0, 0);
    send_request(32'hffffffff, 32'hffffffff, 32'h00000000, 1'b1, 0);
    send_request(32'h1d00ffff, 32'd100, 32'd200, 1'b0, 0);
    send_request(32'h1b0404cb, 32'd500, 32'd500, 1'b1, 0);
    send_request(32'h01123456, 32'd600, 32'd0, 1'b0, 0);
    send_request(32'h02123456, 32'd60, 32'd0, 1'b0, 0);
    send_request(32'h03123456, 32'd30, 32'd0, 1'b1, 0);
    send_request(32'h04923456, 32'd70, 32'd10, 1'b0, 0);
    send_request(32'h20123456, 32'd59, 32'd0, 1'b0, 0);
    send_request(32'h22ffffff, 32'd61, 32'd0, 1'b1, 0);
    send_request(32'h23123456, 32'd60, 32'd0, 1'b0, 0);
    send_request(32'hff7fffff, 32'd60, 32'd0, 1'b1, 0);
    send_request(32'h0400ffff, 32'd0, 32'hffffffff, 1'b0, 0);
    send_request(32'h1a7fffff, 32'd601, 32'd0, 1'b1, 0);
    send_request(32'h00800000, 32'd1, 32'd0, 1'b0, 0);
    wait_idle();

    // Extreme settings, fixed flags and ignored indexes
    set_all(32'd1, 32'd1, 32'hffffffff, 32'h00000000, 1'b0, 1'b1);
    cfg_write(IDX_UNUSED_A, 32'hffffffff);
    cfg_write(IDX_UNUSED_B, 32'h00000000);
    cfg_close();
    send_request(32'h1d00ffff, 32'd5, 32'd0, 1'b0, 0);
    send_request(32'h1d00ffff, 32'd5, 32'd0, 1'b1, 0);
    random_burst(220, 1'b1);
    wait_idle();

    set_all(32'd86400, 32'd16777215, 32'h207fffff, 32'h1e0fffff, 1'b1, 1'b0);
    random_burst(240, 1'b1);
    wait_idle();

    set_all(32'd0, 32'd0, 32'h1d00ffff, 32'h1d00ffff, 1'b0, 1'b0);
    random_burst(240, 1'b0);
    wait_idle();

    set_all(32'd86400, 32'd1, 32'h22ffffff, 32'h03000001, 1'b1, 1'b1);
    random_burst(120, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      set_all($urandom_range(1, 600), $urandom_range(1, 20000), $urandom, $urandom,
              1'($urandom_range(0, 1) & $urandom_range(0, 1)),
              1'($urandom_range(0, 1) & $urandom_range(0, 1)));
      random_burst(260, ph[0]);
      wait_idle();
    end

    set_all({15'd0, SPACING_RST}, {8'd0, TIMESPAN_RST}, LIMIT_RST, LIMIT_RST, 1'b0, 1'b0);
    random_burst(150, 1'b1);
    wait_idle();

    if (sb.errors == 0 && sb.owed_bits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
